### sv/bmpd_pkg.sv
// bmpd_pkg: types and fixed constants shared by the BMP 24-bit stream decoder.
// No dependencies; imported by every decoder module.
package bmpd_pkg;

	localparam int unsigned IDX_W   = 24;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned DIMO_W  = 13;
	localparam int unsigned ADDR_W  = 3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_SIZE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_MAGIC   = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNSUP   = 3'd3;
	localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;

	// header byte positions: the first byte, and where a field's last byte arrives
	localparam logic [31:0] POS_FIRST    = 32'd0;
	localparam logic [31:0] POS_MAGIC    = 32'd1;
	localparam logic [31:0] POS_OFFSET   = 32'd13;
	localparam logic [31:0] POS_INFOSZ   = 32'd17;
	localparam logic [31:0] POS_WIDTH    = 32'd21;
	localparam logic [31:0] POS_HEIGHT   = 32'd25;
	localparam logic [31:0] POS_PLANES   = 32'd27;
	localparam logic [31:0] POS_BITS     = 32'd29;
	localparam logic [31:0] POS_COMPRESS = 32'd33;
	localparam logic [31:0] POS_HDR_END  = 32'd53;

	localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
	localparam logic [31:0] FILE_HDR_LEN  = 32'd14;
	localparam logic [31:0] HDR_LEN       = 32'd54;
	localparam logic [31:0] INFO_HDR_LEN  = 32'd40;
	localparam logic [15:0] PLANES_OK     = 16'd1;
	localparam logic [15:0] BPP_OK        = 16'd24;

	localparam logic [ADDR_W-3:0] REG_FILE_LENGTH = 1'b0;

	typedef struct packed {
		logic [IDX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               pixel_valid;
		logic [STAT_W-1:0]  status;
		logic               done_res;
		logic [DIMO_W-1:0]  image_width;
		logic [DIMO_W-1:0]  image_height;
	} result_t;

endpackage

### sv/bmpd_regs.sv
// bmpd_regs: APB-style register port holding the file length.
// Depends on bmpd_pkg.
module bmpd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [31:0]                 file_length
);
	import bmpd_pkg::*;

	logic [31:0]       file_length_q;
	logic [ADDR_W-3:0] reg_sel;
	logic              wr_en;

	assign reg_sel = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_FILE_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (wr_en) begin
			file_length_q <= pwdata;
		end
	end

	assign prdata      = (reg_sel == REG_FILE_LENGTH) ? file_length_q : '0;
	assign file_length = file_length_q;

endmodule

### sv/bmpd_core.sv
// bmpd_core: header parser, checks, padding skip and pixel assembly.
// One accepted byte is handled per cycle. Depends on bmpd_pkg.
module bmpd_core #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic [31:0]         file_length,
	output logic                res_valid,
	output bmpd_pkg::result_t   res
);
	import bmpd_pkg::*;

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned SW = WW + 2;
	localparam int unsigned PW = SW + HW;
	localparam int unsigned BW = WW + HW;
	localparam int unsigned TW = ((PW > 32) ? PW : 32) + 1;

	phase_t             phase_q, phase_n;
	logic [31:0]        pos_q, pos_n;
	logic [31:0]        shift_q, shift_n;
	logic [31:0]        offset_q, offset_n;
	logic [31:0]        raw_w_q, raw_w_n;
	logic [31:0]        raw_h_q, raw_h_n;
	logic               magic_bad_q, magic_bad_n;
	logic               info_bad_q, info_bad_n;
	logic               planes_bad_q, planes_bad_n;
	logic               bits_bad_q, bits_bad_n;
	logic               comp_bad_q, comp_bad_n;
	logic [WW-1:0]      col_q, col_n;
	logic [HW-1:0]      row_q, row_n;
	logic [SW-1:0]      bir_q, bir_n;
	logic [1:0]         sel_q, sel_n;
	logic [COLOR_W-1:0] blue_q, blue_n;
	logic [COLOR_W-1:0] green_q, green_n;
	logic [IDX_W-1:0]   row_base_q, row_base_n;

	// size terms, recomputed every cycle from the latched header fields;
	// they settle long before the end of the info header
	logic [WW-1:0]      w_c;
	logic [HW-1:0]      h_c;
	logic [SW-1:0]      stride_q, w3_q;
	logic [PW-1:0]      prod_q;
	logic [IDX_W-1:0]   base_q;
	logic [BW-1:0]      base_full_c;
	logic [TW-1:0]      total_c;
	logic [HW-1:0]      hm1_c;
	logic [SW-1:0]      w3_c;

	logic [2:0]         info_st_c;
	logic               in_row_c, pix_c, row_end_c, last_c;
	logic [IDX_W-1:0]   idx_c;
	logic [31:0]        w32_c, h32_c;

	assign w_c   = raw_w_q[WW-1:0];
	assign h_c   = raw_h_q[HW-1:0];
	assign hm1_c = h_c - HW'(1);
	assign w3_c  = SW'({w_c, 1'b0}) + SW'(w_c);
	assign base_full_c = BW'(hm1_c) * BW'(w_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= '0;
			w3_q     <= '0;
			prod_q   <= '0;
			base_q   <= '0;
		end else begin
			w3_q     <= w3_c;
			stride_q <= (w3_c + SW'(3)) & ~SW'(3);
			prod_q   <= PW'(stride_q) * PW'(h_c);
			base_q   <= IDX_W'(base_full_c);
		end
	end

	assign total_c = TW'(offset_q) + TW'(prod_q);

	always_comb begin
		if (info_bad_q || planes_bad_q || bits_bad_q || comp_bad_q) begin
			info_st_c = ST_UNSUP;
		end else if (raw_w_q == '0 || raw_w_q[31] || raw_h_q == '0 || raw_h_q[31]) begin
			info_st_c = ST_INVALID;
		end else if (raw_w_q > 32'(MAX_WIDTH) || raw_h_q > 32'(MAX_HEIGHT)) begin
			info_st_c = ST_UNSUP;
		end else if (total_c > TW'(file_length)) begin
			info_st_c = ST_SIZE;
		end else begin
			info_st_c = ST_OK;
		end
	end

	assign in_row_c  = bir_q < w3_q;
	assign pix_c     = in_row_c && (sel_q == 2'd2);
	assign row_end_c = (bir_q + SW'(1)) == stride_q;
	assign last_c    = row_end_c && ((row_q + HW'(1)) == h_c);
	assign idx_c     = row_base_q + IDX_W'(col_q);
	assign w32_c     = 32'(w_c);
	assign h32_c     = 32'(h_c);

	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		shift_n      = shift_q;
		offset_n     = offset_q;
		raw_w_n      = raw_w_q;
		raw_h_n      = raw_h_q;
		magic_bad_n  = magic_bad_q;
		info_bad_n   = info_bad_q;
		planes_bad_n = planes_bad_q;
		bits_bad_n   = bits_bad_q;
		comp_bad_n   = comp_bad_q;
		col_n        = col_q;
		row_n        = row_q;
		bir_n        = bir_q;
		sel_n        = sel_q;
		blue_n       = blue_q;
		green_n      = green_q;
		row_base_n   = row_base_q;
		res_valid    = 1'b0;
		res          = '0;

		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					shift_n = {data_byte, shift_q[31:8]};
					pos_n   = pos_q + 32'd1;
					case (pos_q)
						POS_MAGIC:    magic_bad_n  = shift_n[31:16] != BMP_MAGIC;
						POS_OFFSET:   offset_n     = shift_n;
						POS_INFOSZ:   info_bad_n   = shift_n != INFO_HDR_LEN;
						POS_WIDTH:    raw_w_n      = shift_n;
						POS_HEIGHT:   raw_h_n      = shift_n;
						POS_PLANES:   planes_bad_n = shift_n[31:16] != PLANES_OK;
						POS_BITS:     bits_bad_n   = shift_n[31:16] != BPP_OK;
						POS_COMPRESS: comp_bad_n   = shift_n != '0;
						default:      ;
					endcase
					if (pos_q == POS_FIRST && file_length < FILE_HDR_LEN) begin
						res_valid = 1'b1;
						res.status = ST_SIZE;
					end else if (pos_q == POS_OFFSET) begin
						res_valid = 1'b1;
						if (magic_bad_q) begin
							res.status = ST_MAGIC;
						end else if (shift_n > file_length || file_length < HDR_LEN) begin
							res.status = ST_SIZE;
						end else if (shift_n < HDR_LEN) begin
							res.status = ST_INVALID;
						end else begin
							res_valid = 1'b0;
						end
					end else if (pos_q == POS_HDR_END) begin
						if (info_st_c != ST_OK) begin
							res_valid  = 1'b1;
							res.status = info_st_c;
						end else begin
							col_n      = '0;
							row_n      = '0;
							bir_n      = '0;
							sel_n      = '0;
							row_base_n = base_q;
							phase_n    = (pos_n == offset_q) ? PH_PIXELS : PH_SKIP;
						end
					end
					if (res_valid) begin
						res.done_res = 1'b1;
						phase_n      = PH_DONE;
					end
				end
				PH_SKIP: begin
					pos_n = pos_q + 32'd1;
					if (pos_n == offset_q) begin
						phase_n = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (in_row_c) begin
						case (sel_q)
							2'd0: begin
								blue_n = data_byte;
								sel_n  = 2'd1;
							end
							2'd1: begin
								green_n = data_byte;
								sel_n   = 2'd2;
							end
							default: begin
								sel_n = 2'd0;
								col_n = col_q + WW'(1);
							end
						endcase
					end
					bir_n = bir_q + SW'(1);
					if (pix_c) begin
						res_valid         = 1'b1;
						res.pixel_index   = idx_c;
						res.blue          = blue_q;
						res.green         = green_q;
						res.red           = data_byte;
						res.pixel_valid   = 1'b1;
					end
					if (row_end_c) begin
						bir_n      = '0;
						col_n      = '0;
						sel_n      = '0;
						row_n      = row_q + HW'(1);
						row_base_n = row_base_q - IDX_W'(w_c);
						if (last_c) begin
							phase_n          = PH_DONE;
							res_valid        = 1'b1;
							res.done_res     = 1'b1;
							res.image_width  = w32_c[DIMO_W-1:0];
							res.image_height = h32_c[DIMO_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			pos_q        <= '0;
			shift_q      <= '0;
			offset_q     <= '0;
			raw_w_q      <= '0;
			raw_h_q      <= '0;
			magic_bad_q  <= 1'b0;
			info_bad_q   <= 1'b0;
			planes_bad_q <= 1'b0;
			bits_bad_q   <= 1'b0;
			comp_bad_q   <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			bir_q        <= '0;
			sel_q        <= '0;
			blue_q       <= '0;
			green_q      <= '0;
			row_base_q   <= '0;
		end else begin
			phase_q      <= phase_n;
			pos_q        <= pos_n;
			shift_q      <= shift_n;
			offset_q     <= offset_n;
			raw_w_q      <= raw_w_n;
			raw_h_q      <= raw_h_n;
			magic_bad_q  <= magic_bad_n;
			info_bad_q   <= info_bad_n;
			planes_bad_q <= planes_bad_n;
			bits_bad_q   <= bits_bad_n;
			comp_bad_q   <= comp_bad_n;
			col_q        <= col_n;
			row_q        <= row_n;
			bir_q        <= bir_n;
			sel_q        <= sel_n;
			blue_q       <= blue_n;
			green_q      <= green_n;
			row_base_q   <= row_base_n;
		end
	end

endmodule

### sv/bmpd_outbuf.sv
// bmpd_outbuf: result register plus one skid entry, so a stalled output
// word does not block the byte accepted in the same cycle. Depends on bmpd_pkg.
module bmpd_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  bmpd_pkg::result_t res,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output bmpd_pkg::result_t out_res
);
	import bmpd_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    out_take;

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

### sv/bmp24_stream_decoder.sv
// bmp24_stream_decoder: one byte per cycle while in_stall is low; the result word
// of a byte is registered in the output register or, if that is held, the skid entry.
// in_stall rises only when the output word and its skid entry are both held.
// Reset (arst_n low, asynchronous) returns the parser to the header phase,
// clears all counters and sets file_length to 0; there is no clearing pass.
// Depends on bmpd_pkg, bmpd_regs, bmpd_core, bmpd_outbuf.
module bmp24_stream_decoder #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bmpd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [23:0]                 pixel_index,
	output logic [7:0]                  blue,
	output logic [7:0]                  green,
	output logic [7:0]                  red,
	output logic                        pixel_valid,
	output logic [2:0]                  status,
	output logic                        done_res,
	output logic [12:0]                 image_width,
	output logic [12:0]                 image_height
);
	import bmpd_pkg::*;

	logic [31:0] file_length;
	logic        accept;
	logic        res_valid;
	result_t     res;
	result_t     out_res;

	assign accept = in_valid && !in_stall;

	bmpd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.file_length (file_length)
	);

	bmpd_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.file_length (file_length),
		.res_valid   (res_valid),
		.res         (res)
	);

	bmpd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign pixel_index  = out_res.pixel_index;
	assign blue         = out_res.blue;
	assign green        = out_res.green;
	assign red          = out_res.red;
	assign pixel_valid  = out_res.pixel_valid;
	assign status       = out_res.status;
	assign done_res     = out_res.done_res;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;

endmodule

### sv/bmpd_checker.sv
// bmpd_checker: port-level checks on the decoder's output words, bound to
// bmp24_stream_decoder. Depends on bmpd_pkg and the top level's ports.
module bmpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] pixel_index,
	input logic [7:0]  blue,
	input logic [7:0]  green,
	input logic [7:0]  red,
	input logic        pixel_valid,
	input logic [2:0]  status,
	input logic        done_res
);
	import bmpd_pkg::*;

	// an error always ends the file
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> done_res)
		else $error("error status without done");

	// pixel words never carry an error
	a_pix_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> (status == ST_OK))
		else $error("pixel word with error status");

	// the done word is the last word of the file
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && done_res |=> !out_valid)
		else $error("word after done");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(status)
			&& $stable(red) && $stable(blue) && $stable(green))
		else $error("stalled word changed");

endmodule

bind bmp24_stream_decoder bmpd_checker u_bmpd_checker (.*);
